FILE: hdl/pfc_pkg.sv
// ----------------------------------------------------------------------------
// pfc_pkg
// Types, constants and helper functions for the 5x5 digram cipher.
// ----------------------------------------------------------------------------
`default_nettype none

package pfc_pkg;

   localparam int LETTER_W         = 5;
   localparam int SIDE             = 5;
   localparam int CELLS            = SIDE * SIDE;
   localparam int SQUARE_W         = CELLS * LETTER_W;
   localparam int PART_A_W         = 45;
   localparam int PART_B_W         = 40;
   localparam int PART_C_W         = 40;
   localparam int CSR_DATA_W       = 45;
   localparam int CSR_INDEX_W      = 2;
   localparam int REQ_DATA_W       = 8;
   localparam int RSP_DATA_W       = 8;
   localparam int PAIR_QUEUE_DEPTH = 2;

   localparam logic [LETTER_W-1:0] CODE_X = 5'd23;
   localparam logic [LETTER_W-1:0] CODE_I = 5'd8;
   localparam logic [LETTER_W-1:0] CODE_J = 5'd9;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SQUARE_A = 2'd0,
      CSR_SQUARE_B = 2'd1,
      CSR_SQUARE_C = 2'd2,
      CSR_DECRYPT  = 2'd3
   } csr_index_type;

   typedef logic [SQUARE_W-1:0] square_type;
   typedef logic [2:0]          coord_type;

   typedef struct packed {
      logic [LETTER_W-1:0] first;
      logic [LETTER_W-1:0] second;
      logic                last;
   } pair_type;

   typedef struct packed {
      coord_type row;
      coord_type col;
   } pos_type;

   function automatic logic [LETTER_W-1:0] norm_letter(input logic [LETTER_W-1:0] c);
      return (c == CODE_J) ? CODE_I : c;
   endfunction

   // lowest numbered matching cell wins; no match gives row 0, column 0
   function automatic pos_type locate(input square_type sq, input logic [LETTER_W-1:0] c);
      pos_type p;
      p.row = '0;
      p.col = '0;
      for (int r = SIDE - 1; r >= 0; r--) begin
         for (int k = SIDE - 1; k >= 0; k--) begin
            if (sq[LETTER_W*(SIDE*r+k) +: LETTER_W] == c) begin
               p.row = coord_type'(r);
               p.col = coord_type'(k);
            end
         end
      end
      return p;
   endfunction

   function automatic logic [LETTER_W-1:0] cell_at(input square_type sq, input coord_type row,
                                                   input coord_type col);
      logic [LETTER_W-1:0] v;
      v = '0;
      for (int r = 0; r < SIDE; r++) begin
         for (int k = 0; k < SIDE; k++) begin
            if (row == coord_type'(r) && col == coord_type'(k))
               v = sq[LETTER_W*(SIDE*r+k) +: LETTER_W];
         end
      end
      return v;
   endfunction

   function automatic coord_type step_pos(input coord_type x, input logic backward);
      coord_type v;
      if (backward)
         v = (x == '0) ? coord_type'(SIDE - 1) : x - 3'd1;
      else
         v = (x == coord_type'(SIDE - 1)) ? '0 : x + 3'd1;
      return v;
   endfunction

endpackage

`default_nettype wire

FILE: hdl/pfc_front.sv
// ----------------------------------------------------------------------------
// pfc_front
// Accepts letters, normalises J to I and forms pairs, padding a lone last
// letter with X.
// ----------------------------------------------------------------------------
`default_nettype none

module pfc_front (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         req_tvalid,
   output logic                        req_tready,
   input  wire  [pfc_pkg::LETTER_W-1:0] letter,
   input  wire                         last,
   output logic                        push,
   output pfc_pkg::pair_type           push_pair,
   input  wire                         queue_full
);
   import pfc_pkg::*;

   logic [LETTER_W-1:0] held_letter_ff, held_letter_in;
   logic                held_valid_ff, held_valid_in;
   logic [LETTER_W-1:0] norm;
   logic                xfer;

   assign req_tready = !queue_full;
   assign xfer       = req_tvalid && req_tready;
   assign norm       = norm_letter(letter);

   always_comb begin
      held_letter_in   = held_letter_ff;
      held_valid_in    = held_valid_ff;
      push             = 1'b0;
      push_pair.first  = norm;
      push_pair.second = CODE_X;
      push_pair.last   = last;
      if (xfer) begin
         if (held_valid_ff) begin
            push_pair.first  = held_letter_ff;
            push_pair.second = norm;
            push             = 1'b1;
            held_valid_in    = 1'b0;
            held_letter_in   = '0;
         end else if (last) begin
            push = 1'b1;
         end else begin
            held_letter_in = norm;
            held_valid_in  = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_letter_ff <= '0;
         held_valid_ff  <= 1'b0;
      end else begin
         held_letter_ff <= held_letter_in;
         held_valid_ff  <= held_valid_in;
      end
   end

endmodule

`default_nettype wire

FILE: hdl/pfc_pair_queue.sv
// ----------------------------------------------------------------------------
// pfc_pair_queue
// Small FIFO of letter pairs between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module pfc_pair_queue #(
   parameter int DEPTH = pfc_pkg::PAIR_QUEUE_DEPTH
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                push,
   input  pfc_pkg::pair_type  push_pair,
   output logic               full,
   input  wire                pop,
   output pfc_pkg::pair_type  head,
   output logic               empty
);
   import pfc_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

   pair_type         store_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push)
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      if (do_pop)
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      if (do_push && !do_pop)
         count_in = count_ff + 1'b1;
      else if (do_pop && !do_push)
         count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push)
         store_ff[wr_ptr_ff] <= push_pair;
   end

endmodule

`default_nettype wire

FILE: hdl/pfc_back.sv
// ----------------------------------------------------------------------------
// pfc_back
// Locates both letters of a pair in the key square, applies the row, column
// or rectangle rule and sends the two result letters one per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module pfc_back (
   input  wire                          clock,
   input  wire                          reset,
   input  pfc_pkg::square_type          square,
   input  wire                          decrypt,
   input  pfc_pkg::pair_type            head,
   input  wire                          empty,
   output logic                         pop,
   output logic                         rsp_tvalid,
   input  wire                          rsp_tready,
   output logic [pfc_pkg::LETTER_W-1:0] letter_out,
   output logic                         end_of_message
);
   import pfc_pkg::*;

   // locate stage
   pos_type             pa_ff, pb_ff;
   logic                s1_last_ff;
   logic                s1_valid_ff, s1_valid_in;

   // result buffer
   logic [LETTER_W-1:0] oa_ff, ob_ff, oa_in, ob_in;
   logic                last_ff;
   logic                phase_ff, phase_in;
   logic                out_valid_ff, out_valid_in;

   logic                buf_free, load_buf, load_s1, rsp_xfer;

   assign rsp_xfer   = out_valid_ff && rsp_tready;
   assign buf_free   = !out_valid_ff || (rsp_xfer && phase_ff);
   assign load_buf   = s1_valid_ff && buf_free;
   assign load_s1    = !empty && (!s1_valid_ff || load_buf);
   assign pop        = load_s1;

   assign rsp_tvalid     = out_valid_ff;
   assign letter_out     = phase_ff ? ob_ff : oa_ff;
   assign end_of_message = phase_ff && last_ff;

   always_comb begin
      if (pa_ff.row == pb_ff.row) begin
         oa_in = cell_at(square, pa_ff.row, step_pos(pa_ff.col, decrypt));
         ob_in = cell_at(square, pb_ff.row, step_pos(pb_ff.col, decrypt));
      end else if (pa_ff.col == pb_ff.col) begin
         oa_in = cell_at(square, step_pos(pa_ff.row, decrypt), pa_ff.col);
         ob_in = cell_at(square, step_pos(pb_ff.row, decrypt), pb_ff.col);
      end else begin
         oa_in = cell_at(square, pa_ff.row, pb_ff.col);
         ob_in = cell_at(square, pb_ff.row, pa_ff.col);
      end
   end

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      if (load_s1)
         s1_valid_in = 1'b1;
      else if (load_buf)
         s1_valid_in = 1'b0;

      phase_in     = phase_ff;
      out_valid_in = out_valid_ff;
      if (load_buf) begin
         phase_in     = 1'b0;
         out_valid_in = 1'b1;
      end else if (rsp_xfer) begin
         if (phase_ff)
            out_valid_in = 1'b0;
         else
            phase_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         phase_ff     <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         phase_ff     <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_s1) begin
         pa_ff      <= locate(square, head.first);
         pb_ff      <= locate(square, head.second);
         s1_last_ff <= head.last;
      end
      if (load_buf) begin
         oa_ff   <= oa_in;
         ob_ff   <= ob_in;
         last_ff <= s1_last_ff;
      end
   end

endmodule

`default_nettype wire

FILE: hdl/playfair_digram_cipher.sv
// ----------------------------------------------------------------------------
// playfair_digram_cipher
// Digram substitution over a configurable 5x5 key square.
// ----------------------------------------------------------------------------
// Letters (A=0, J read as I) arrive on the req_ stream, one per transfer,
// with tlast on the final letter of a message. Every two letters form a
// pair; a lone last letter is paired with X. Each pair gives two letters on
// the rsp_ stream, tlast set on the second letter of a message's final pair.
// The key square and the encrypt/decrypt select are written over the csr_
// port; the user must write them only while the block is idle, as the
// block itself does not enforce it. Cells are packed five bits apiece, cell
// 0 in the low bits of register 0. Throughput is one letter per cycle on
// both sides while the rsp_ side is not stalled. A pair enters the queue on
// the transfer that completes it, is located (a 25-way compare per letter)
// into the locate stage and is then loaded, substituted, into the result
// buffer, which then presents its first result letter.
// The result buffer presents the two letters in turn, so a stalled rsp_
// side fills the locate stage and the pair queue before req_tready drops.
// Reset (synchronous) clears the held letter, the queue, the pipeline and
// all configuration registers.
// ----------------------------------------------------------------------------
`default_nettype none

module playfair_digram_cipher #(
   parameter int PAIR_QUEUE_DEPTH = pfc_pkg::PAIR_QUEUE_DEPTH
) (
   input  wire                             clock,
   input  wire                             reset,
   // req_tdata: [4:0] letter_in, [7:5] zero
   input  wire                             req_tvalid,
   output logic                            req_tready,
   input  wire  [pfc_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  wire                             req_tlast,
   // rsp_tdata: [4:0] letter_out, [7:5] zero
   output logic                            rsp_tvalid,
   input  wire                             rsp_tready,
   output logic [pfc_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                            rsp_tlast,
   input  wire                             csr_we,
   input  wire  [pfc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire  [pfc_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import pfc_pkg::*;

   logic [PART_A_W-1:0] part_a_ff;
   logic [PART_B_W-1:0] part_b_ff;
   logic [PART_C_W-1:0] part_c_ff;
   logic                decrypt_ff;
   square_type          square;

   logic                push, pop, full, empty;
   pair_type            push_pair, head;
   logic [LETTER_W-1:0] letter_out;

   always_ff @(posedge clock) begin
      if (reset) begin
         part_a_ff  <= '0;
         part_b_ff  <= '0;
         part_c_ff  <= '0;
         decrypt_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_SQUARE_A: part_a_ff  <= csr_wdata[PART_A_W-1:0];
            CSR_SQUARE_B: part_b_ff  <= csr_wdata[PART_B_W-1:0];
            CSR_SQUARE_C: part_c_ff  <= csr_wdata[PART_C_W-1:0];
            CSR_DECRYPT:  decrypt_ff <= csr_wdata[0];
            default:      decrypt_ff <= decrypt_ff;
         endcase
      end
   end

   assign square = {part_c_ff, part_b_ff, part_a_ff};

   pfc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .letter     (req_tdata[LETTER_W-1:0]),
      .last       (req_tlast),
      .push       (push),
      .push_pair  (push_pair),
      .queue_full (full)
   );

   pfc_pair_queue #(
      .DEPTH (PAIR_QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_pair (push_pair),
      .full      (full),
      .pop       (pop),
      .head      (head),
      .empty     (empty)
   );

   pfc_back u_back (
      .clock          (clock),
      .reset          (reset),
      .square         (square),
      .decrypt        (decrypt_ff),
      .head           (head),
      .empty          (empty),
      .pop            (pop),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .letter_out     (letter_out),
      .end_of_message (rsp_tlast)
   );

   assign rsp_tdata = {(RSP_DATA_W - LETTER_W)'(0), letter_out};

endmodule

`default_nettype wire
